// File: sv/e2u_pkg.sv
package e2u_pkg;

  // Width of the signed seconds count.
  localparam int SECONDS_W = 36;
  // Width of the shared adder and of the signed seconds count being walked.
  localparam int DW = SECONDS_W + 2;

  localparam longint SEC_PER_DAY = 86400;
  localparam longint SEC_PER_HOUR = 3600;
  localparam longint SEC_PER_MIN = 60;
  localparam int DAYS_PER_WEEK = 7;
  localparam int DAYS_COMMON = 365;
  localparam int DAYS_LEAP = 366;
  localparam longint SEC_PER_COMMON_YEAR = DAYS_COMMON * SEC_PER_DAY;
  localparam longint SEC_PER_LEAP_YEAR = DAYS_LEAP * SEC_PER_DAY;

  // 1970-01-01 was a Thursday.
  localparam int WEEKDAY_OFS = 4;
  localparam int EPOCH_YEAR_OFS = 1970 - 1900;
  localparam int EPOCH_MOD400 = 1970 % 400;
  localparam int EPOCH_MOD100 = 1970 % 100;
  localparam logic [3:0] MONTH_FEB = 4'd1;
  localparam logic [3:0] MONTH_DEC = 4'd11;

  typedef struct packed {
    logic [DW-1:0] a;
    logic [DW-1:0] b;
    logic          sub;
  } alu_req_t;

  typedef struct packed {
    logic [5:0]        second_of_minute;
    logic [5:0]        minute_of_hour;
    logic [4:0]        hour_of_day;
    logic [4:0]        day_of_month;
    logic [3:0]        month_index;
    logic signed [11:0] year_since_1900;
    logic [2:0]        weekday;
    logic [8:0]        day_of_year;
  } cal_res_t;

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    unique case (m)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd1: len = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// File: sv/e2u_if.sv
interface e2u_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [e2u_pkg::SECONDS_W-1:0] epoch_seconds;

  modport source(output valid, output epoch_seconds, input ready);
  modport sink(input valid, input epoch_seconds, output ready);
endinterface

interface e2u_out_if;
  logic              valid;
  logic              ready;
  logic [5:0]        second_of_minute;
  logic [5:0]        minute_of_hour;
  logic [4:0]        hour_of_day;
  logic [4:0]        day_of_month;
  logic [3:0]        month_index;
  logic signed [11:0] year_since_1900;
  logic [2:0]        weekday;
  logic [8:0]        day_of_year;

  modport source(output valid, output second_of_minute, output minute_of_hour,
                 output hour_of_day, output day_of_month, output month_index,
                 output year_since_1900, output weekday, output day_of_year,
                 input ready);
  modport sink(input valid, input second_of_minute, input minute_of_hour,
               input hour_of_day, input day_of_month, input month_index,
               input year_since_1900, input weekday, input day_of_year,
               output ready);
endinterface

// File: sv/e2u_alu.sv
module e2u_alu (
  input  e2u_pkg::alu_req_t        req,
  output logic [e2u_pkg::DW-1:0]   res
);

  assign res = req.sub ? (req.a - req.b) : (req.a + req.b);

endmodule

// File: sv/e2u_seq.sv
module e2u_seq (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [e2u_pkg::SECONDS_W-1:0] secs,
  input  logic                                 take,
  output logic                                 idle,
  output logic                                 res_valid,
  output e2u_pkg::cal_res_t                    res
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_YEAR  = 3'd1;
  localparam logic [2:0] S_MONTH = 3'd2;
  localparam logic [2:0] S_DAY   = 3'd3;
  localparam logic [2:0] S_HOUR  = 3'd4;
  localparam logic [2:0] S_MIN   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam int DW = e2u_pkg::DW;
  localparam int SW = e2u_pkg::SECONDS_W;

  logic [2:0]          state_r, state_nxt;
  logic [DW-1:0]       acc_r, acc_nxt;
  logic [11:0]         year_r, year_nxt;
  logic [8:0]          m400_r, m400_nxt;
  logic [6:0]          m100_r, m100_nxt;
  logic [3:0]          month_r, month_nxt;
  logic [4:0]          hour_r, hour_nxt;
  logic [5:0]          min_r, min_nxt;
  logic [5:0]          sec_r, sec_nxt;
  logic [2:0]          wday_r, wday_nxt;
  logic [8:0]          doy_r, doy_nxt;
  logic [4:0]          dom_r, dom_nxt;

  e2u_pkg::alu_req_t   alu_req;
  logic [DW-1:0]       alu_res;
  logic                alu_neg;
  logic [8:0]          p400, n400;
  logic [6:0]          p100, n100;
  logic                acc_neg;
  logic                leap_cur;
  logic                leap_prev;
  logic                yr_leap;
  logic [1:0]          yr_shift;
  logic [4:0]          mlen;
  logic [DW-1:0]       mlen_secs;

  function automatic logic is_leap(input logic [8:0] m400, input logic [6:0] m100);
    return ((m400[1:0] == 2'd0) && (m100 != 7'd0)) || (m400 == 9'd0);
  endfunction

  function automatic logic [2:0] wk_fwd(input logic [2:0] w, input logic [1:0] d);
    logic [3:0] sum;
    sum = {1'b0, w} + {2'b00, d};
    return (sum >= 4'(e2u_pkg::DAYS_PER_WEEK)) ? 3'(sum - 4'(e2u_pkg::DAYS_PER_WEEK))
                                               : sum[2:0];
  endfunction

  function automatic logic [2:0] wk_back(input logic [2:0] w, input logic [1:0] d);
    logic [3:0] diff;
    diff = {1'b0, w} + 4'(e2u_pkg::DAYS_PER_WEEK) - {2'b00, d};
    return (diff >= 4'(e2u_pkg::DAYS_PER_WEEK)) ? 3'(diff - 4'(e2u_pkg::DAYS_PER_WEEK))
                                                : diff[2:0];
  endfunction

  e2u_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  // Year residues are tracked as wrapping counters so no division is needed.
  assign p400 = (m400_r == 9'd0) ? 9'd399 : m400_r - 9'd1;
  assign n400 = (m400_r == 9'd399) ? 9'd0 : m400_r + 9'd1;
  assign p100 = (m100_r == 7'd0) ? 7'd99 : m100_r - 7'd1;
  assign n100 = (m100_r == 7'd99) ? 7'd0 : m100_r + 7'd1;

  assign acc_neg   = acc_r[DW-1];
  assign leap_cur  = is_leap(m400_r, m100_r);
  assign leap_prev = is_leap(p400, p100);
  // Walking backward adds the length of the year before the current one.
  assign yr_leap   = acc_neg ? leap_prev : leap_cur;
  // A common year moves the weekday on by one, a leap year by two.
  assign yr_shift  = yr_leap ? 2'd2 : 2'd1;
  assign mlen = e2u_pkg::month_len(month_r)
              + {4'd0, (month_r == e2u_pkg::MONTH_FEB) && leap_cur};
  assign alu_neg = alu_res[DW-1];

  // Month lengths run from 28 to 31 days, so the low two bits pick the length.
  always_comb begin
    unique case (mlen[1:0])
      2'd0: mlen_secs = DW'(e2u_pkg::SEC_PER_DAY * 28);
      2'd1: mlen_secs = DW'(e2u_pkg::SEC_PER_DAY * 29);
      2'd2: mlen_secs = DW'(e2u_pkg::SEC_PER_DAY * 30);
      default: mlen_secs = DW'(e2u_pkg::SEC_PER_DAY * 31);
    endcase
  end

  always_comb begin
    alu_req.a   = acc_r;
    alu_req.b   = '0;
    alu_req.sub = 1'b1;
    unique case (state_r)
      S_YEAR: begin
        alu_req.b   = yr_leap ? DW'(e2u_pkg::SEC_PER_LEAP_YEAR)
                              : DW'(e2u_pkg::SEC_PER_COMMON_YEAR);
        alu_req.sub = !acc_neg;
      end
      S_MONTH: alu_req.b = mlen_secs;
      S_DAY:   alu_req.b = DW'(e2u_pkg::SEC_PER_DAY);
      S_HOUR:  alu_req.b = DW'(e2u_pkg::SEC_PER_HOUR);
      S_MIN:   alu_req.b = DW'(e2u_pkg::SEC_PER_MIN);
      default: alu_req.b = '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    year_nxt  = year_r;
    m400_nxt  = m400_r;
    m100_nxt  = m100_r;
    month_nxt = month_r;
    hour_nxt  = hour_r;
    min_nxt   = min_r;
    sec_nxt   = sec_r;
    wday_nxt  = wday_r;
    doy_nxt   = doy_r;
    dom_nxt   = dom_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          acc_nxt   = {{(DW-SW){secs[SW-1]}}, secs};
          year_nxt  = 12'(e2u_pkg::EPOCH_YEAR_OFS);
          m400_nxt  = 9'(e2u_pkg::EPOCH_MOD400);
          m100_nxt  = 7'(e2u_pkg::EPOCH_MOD100);
          wday_nxt  = 3'(e2u_pkg::WEEKDAY_OFS);
          state_nxt = S_YEAR;
        end
      end
      S_YEAR: begin
        if (acc_neg) begin
          acc_nxt  = alu_res;
          year_nxt = year_r - 12'd1;
          m400_nxt = p400;
          m100_nxt = p100;
          wday_nxt = wk_back(wday_r, yr_shift);
        end else if (!alu_neg) begin
          acc_nxt  = alu_res;
          year_nxt = year_r + 12'd1;
          m400_nxt = n400;
          m100_nxt = n100;
          wday_nxt = wk_fwd(wday_r, yr_shift);
        end else begin
          doy_nxt   = '0;
          month_nxt = '0;
          state_nxt = S_MONTH;
        end
      end
      S_MONTH: begin
        if ((month_r == e2u_pkg::MONTH_DEC) || alu_neg) begin
          dom_nxt   = 5'd1;
          state_nxt = S_DAY;
        end else begin
          acc_nxt   = alu_res;
          month_nxt = month_r + 4'd1;
          doy_nxt   = doy_r + {4'd0, mlen};
          // 28 days leave the weekday alone; each day beyond moves it on by one.
          wday_nxt  = wk_fwd(wday_r, mlen[1:0]);
        end
      end
      S_DAY: begin
        if (alu_neg) begin
          hour_nxt  = '0;
          state_nxt = S_HOUR;
        end else begin
          acc_nxt  = alu_res;
          dom_nxt  = dom_r + 5'd1;
          doy_nxt  = doy_r + 9'd1;
          wday_nxt = wk_fwd(wday_r, 2'd1);
        end
      end
      S_HOUR: begin
        if (alu_neg) begin
          min_nxt   = '0;
          state_nxt = S_MIN;
        end else begin
          acc_nxt  = alu_res;
          hour_nxt = hour_r + 5'd1;
        end
      end
      S_MIN: begin
        if (alu_neg) begin
          sec_nxt   = acc_r[5:0];
          state_nxt = S_DONE;
        end else begin
          acc_nxt = alu_res;
          min_nxt = min_r + 6'd1;
        end
      end
      S_DONE: begin
        if (take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    year_r  <= year_nxt;
    m400_r  <= m400_nxt;
    m100_r  <= m100_nxt;
    month_r <= month_nxt;
    hour_r  <= hour_nxt;
    min_r   <= min_nxt;
    sec_r   <= sec_nxt;
    wday_r  <= wday_nxt;
    doy_r   <= doy_nxt;
    dom_r   <= dom_nxt;
  end

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);

  always_comb begin
    res.second_of_minute = sec_r;
    res.minute_of_hour   = min_r;
    res.hour_of_day      = hour_r;
    res.day_of_month     = dom_r;
    res.month_index      = month_r;
    res.year_since_1900  = $signed(year_r);
    res.weekday          = wday_r;
    res.day_of_year      = doy_r;
  end

endmodule

// File: sv/epoch_to_utc_calendar.sv
// Converts a signed count of seconds since 1970-01-01 00:00:00 UTC into the
// broken-down UTC calendar fields (second, minute, hour, day of month, month,
// year minus 1900, weekday, day of year). One word is worked on at a time by a
// single shared adder under a small sequencer, which subtracts whole years from
// the seconds count (or adds them back for dates before 1970), then months, days,
// hours and minutes, keeping the weekday on the way. The year walk grows with the
// distance from 1970, so words at the ends of the 36-bit range take longest.
// The input is not ready while a word is being converted; a finished result
// waits in an output register, and the next word may be taken meanwhile.
module epoch_to_utc_calendar (
  input  logic        clk,
  input  logic        rst_n,
  e2u_in_if.sink      in_ch,
  e2u_out_if.source   out_ch
);

  logic              seq_idle;
  logic              res_valid;
  logic              res_take;
  e2u_pkg::cal_res_t seq_res;
  logic              out_valid_r, out_valid_nxt;
  e2u_pkg::cal_res_t out_res_r, out_res_nxt;

  e2u_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_ch.valid && in_ch.ready),
    .secs      (in_ch.epoch_seconds),
    .take      (res_take),
    .idle      (seq_idle),
    .res_valid (res_valid),
    .res       (seq_res)
  );

  assign in_ch.ready = seq_idle;
  assign res_take    = res_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = seq_res;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.second_of_minute = out_res_r.second_of_minute;
  assign out_ch.minute_of_hour   = out_res_r.minute_of_hour;
  assign out_ch.hour_of_day      = out_res_r.hour_of_day;
  assign out_ch.day_of_month     = out_res_r.day_of_month;
  assign out_ch.month_index      = out_res_r.month_index;
  assign out_ch.year_since_1900  = out_res_r.year_since_1900;
  assign out_ch.weekday          = out_res_r.weekday;
  assign out_ch.day_of_year      = out_res_r.day_of_year;

`ifndef SYNTHESIS
  // A word just taken keeps the input closed while it is converted.
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input ready right after a word was taken");

  // A result handed over lands in the output register and frees the sequencer.
  a_handover: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |=> out_ch.valid && in_ch.ready)
    else $error("result handover lost");

  a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.month_index <= 4'd11 && out_ch.hour_of_day <= 5'd23
                     && out_ch.weekday <= 3'd6 && out_ch.day_of_month != 5'd0)
    else $error("calendar field out of range");
`endif

endmodule

// File: test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;

  e2u_in_if  in_ch();
  e2u_out_if out_ch();

  epoch_to_utc_calendar u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  e2u_pkg::cal_res_t pending_calendars[$];
  e2u_pkg::cal_res_t want;
  int       field_mismatches;
  int       burst_left;
  bit       gaps_off;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic bit gregorian_leap(input longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint days_in_year(input longint y);
    return gregorian_leap(y) ? 366 : 365;
  endfunction

  function automatic longint days_in_month(input int m, input bit leap);
    longint n;
    case (m)
      1: n = leap ? 29 : 28;
      3, 5, 8, 10: n = 30;
      default: n = 31;
    endcase
    return n;
  endfunction

  // Breaks a signed seconds count down into the UTC calendar fields.
  function automatic e2u_pkg::cal_res_t split_epoch(
    input logic signed [e2u_pkg::SECONDS_W-1:0] s);
    e2u_pkg::cal_res_t r;
    longint   secs;
    longint   days;
    longint   tod;
    longint   wday;
    longint   year;
    int       month;
    secs = longint'(s);
    days = secs / 86400;
    tod  = secs % 86400;
    if (tod < 0) begin
      tod += 86400;
      days -= 1;
    end
    wday = (days + 4) % 7;
    if (wday < 0) wday += 7;
    year = 1970;
    forever begin
      if (days >= days_in_year(year)) begin
        days -= days_in_year(year);
        year++;
      end else if (days < 0) begin
        year--;
        days += days_in_year(year);
      end else begin
        break;
      end
    end
    r.weekday         = 3'(wday);
    r.year_since_1900 = 12'(year - 1900);
    r.day_of_year     = 9'(days);
    month = 0;
    while (month < 11 && days >= days_in_month(month, gregorian_leap(year))) begin
      days -= days_in_month(month, gregorian_leap(year));
      month++;
    end
    r.second_of_minute = 6'(tod % 60);
    r.minute_of_hour   = 6'((tod / 60) % 60);
    r.hour_of_day      = 5'(tod / 3600);
    r.day_of_month     = 5'(days + 1);
    r.month_index      = 4'(month);
    return r;
  endfunction

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
      field_mismatches++;
    end
  endtask

  // Every accepted word gets its calendar worked out at once.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      pending_calendars.push_back(split_epoch(in_ch.epoch_seconds));
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_calendars.size() == 0) begin
        $display("%0t: result word with no conversion outstanding", $time);
        field_mismatches++;
      end else begin
        want = pending_calendars.pop_front();
        check_field("second_of_minute", int'(want.second_of_minute),
                    int'(out_ch.second_of_minute));
        check_field("minute_of_hour", int'(want.minute_of_hour),
                    int'(out_ch.minute_of_hour));
        check_field("hour_of_day", int'(want.hour_of_day),
                    int'(out_ch.hour_of_day));
        check_field("day_of_month", int'(want.day_of_month),
                    int'(out_ch.day_of_month));
        check_field("month_index", int'(want.month_index),
                    int'(out_ch.month_index));
        check_field("year_since_1900", int'(want.year_since_1900),
                    int'(out_ch.year_since_1900));
        check_field("weekday", int'(want.weekday), int'(out_ch.weekday));
        check_field("day_of_year", int'(want.day_of_year),
                    int'(out_ch.day_of_year));
      end
    end
  end

  // The receiver alternates between calm stretches and stretches with stalls.
  initial begin
    int stall_left;
    int phase_left;
    bit calm;
    out_ch.ready = 1'b0;
    stall_left = 0;
    phase_left = 0;
    calm = 1'b0;
    forever begin
      @(negedge clk);
      if (phase_left == 0) begin
        calm = ($urandom_range(0, 2) == 0);
        phase_left = $urandom_range(500, 3000);
      end
      phase_left--;
      if (calm) begin
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 40);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_word(input longint s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (!gaps_off) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 1500) : $urandom_range(1, 20);
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_ch.valid         <= 1'b1;
    in_ch.epoch_seconds <= s[e2u_pkg::SECONDS_W-1:0];
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
  endtask

  task automatic test_time_of_day_edges();
    send_word(64'sd0);
    send_word(64'sd1);
    send_word(-64'sd1);
    send_word(64'sd59);
    send_word(64'sd60);
    send_word(64'sd3599);
    send_word(64'sd3600);
    send_word(64'sd86399);
    send_word(64'sd86400);
    send_word(-64'sd86400);
    send_word(-64'sd86401);
    send_word((64'sd1 <<< (e2u_pkg::SECONDS_W - 1)) - 1);
    send_word(-(64'sd1 <<< (e2u_pkg::SECONDS_W - 1)));
  endtask

  // Leap days around century years, year ends and the 32-bit limits.
  task automatic test_leap_rules();
    send_word(64'sd951782400);
    send_word(64'sd951868799);
    send_word(64'sd951868800);
    send_word(64'sd978307199);
    send_word(-64'sd2203891201);
    send_word(-64'sd2203891200);
    send_word(64'sd13574563200);
    send_word(-64'sd63158401);
    send_word(64'sd2147483647);
    send_word(-64'sd2147483648);
  endtask

  // Dates within a few decades of 1970 keep the year walk short.
  task automatic test_random_near_epoch(input int count);
    longint s;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) gaps_off = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0)
        s = longint'(int'($urandom_range(0, 40000) - 20000)) * 86400
            + $urandom_range(0, 2) - 1;
      else
        s = longint'(int'($urandom()));
      send_word(s);
    end
    gaps_off = 1'b0;
  endtask

  task automatic test_random_full_range(input int count);
    logic [e2u_pkg::SECONDS_W-1:0] raw;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) gaps_off = ($urandom_range(0, 3) == 0);
      raw = {4'($urandom_range(0, 15)), 32'($urandom())};
      send_word(longint'(raw));
    end
    gaps_off = 1'b0;
  endtask

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.epoch_seconds = '0;
    field_mismatches    = 0;
    burst_left          = 0;
    gaps_off            = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    test_time_of_day_edges();
    test_leap_rules();
    test_random_near_epoch(260);
    test_random_full_range(190);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_calendars.size() != 0) @(posedge clk);
    repeat (1400) @(posedge clk);
    if (field_mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: files.f
sv/e2u_pkg.sv
sv/e2u_if.sv
sv/e2u_alu.sv
sv/e2u_seq.sv
sv/epoch_to_utc_calendar.sv
test/testbench.sv
